/* hdl/frc_pkg.sv */
// Package for the frame cache: entry and control types shared by the cell row
// and the top level. No dependencies.

package frc_pkg;

    localparam int WORD_W = 32;
    localparam int SLOT_W = 3;
    localparam int KIND_W = 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_LOOKUP = 2'd0;
    localparam kind_t KIND_INSERT = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    localparam word_t NEG_ONE = '1;

    typedef struct packed {
        word_t key;
        word_t image;
        word_t layer;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_WRITE,
        CELL_UPDATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_CLEAR
    } state_t;

endpackage

/* hdl/frc_cell.sv */
// One entry of the frame cache: valid bit, key and handles, plus its key compare.
// Depends on frc_pkg. Takes its upper neighbor's entry on a shift.

module frc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  frc_pkg::cell_ctrl_t ctrl,
    input  frc_pkg::entry_t   write_data,
    input  logic              nb_valid,
    input  frc_pkg::entry_t   nb_data,
    input  frc_pkg::word_t    match_key,
    output logic              valid,
    output frc_pkg::entry_t   data,
    output logic              match
);
    import frc_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (ctrl.op)
            CELL_SHIFT:
            begin
                valid_next = nb_valid;
                data_next  = nb_data;
            end
            CELL_WRITE:
            begin
                valid_next = 1'b1;
                data_next  = write_data;
            end
            CELL_UPDATE:
            begin
                data_next.image = write_data.image;
                data_next.layer = write_data.layer;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign match = valid_reg && (data_reg.key == match_key);

endmodule

/* hdl/fifo_replacement_frame_cache_top.sv */
// Top level of the frame cache: a row of entry cells, the command decode,
// the clear sequencer and the result register. Depends on frc_pkg and frc_cell.
//
// Channel   Handshake          Signals
// command   start, busy        kind, frame_number, image_handle, layer_handle
// result    done (strobe)      found, slot, image_out, layer_out, release_res, last
//
// A lookup or insert result strobes in the cycle after the command is taken;
// another command may follow at once, since matching is parallel over all cells
// and eviction is a one-place shift of the row. A clear of n stored entries keeps
// busy high until all n are drained, sending one result beat per cycle from cell 0
// while the row shifts down. Reset empties the table; entry payloads are not reset.
// The receiver cannot stall: each result beat is shown for exactly one cycle.

module fifo_replacement_frame_cache_top #(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  frc_pkg::kind_t        kind,
    input  logic signed [31:0]    frame_number,
    input  logic signed [31:0]    image_handle,
    input  logic signed [31:0]    layer_handle,
    output logic                  done,
    output logic                  found,
    output frc_pkg::slot_t        slot,
    output logic signed [31:0]    image_out,
    output logic signed [31:0]    layer_out,
    output logic                  release_res,
    output logic                  last
);
    import frc_pkg::*;

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CACHE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam slot_t            SLOT_TOP = SLOT_W'(CACHE_ENTRIES - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic  done_reg, done_next;
    logic  found_reg, found_next;
    slot_t slot_reg, slot_next;
    word_t image_reg, image_next;
    word_t layer_reg, layer_next;
    logic  release_reg, release_next;
    logic  last_reg, last_next;

    cell_ctrl_t cell_ctrl [CACHE_ENTRIES];
    logic       cell_valid [CACHE_ENTRIES];
    entry_t     cell_data [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] match_vec;
    logic [CACHE_ENTRIES-1:0] valid_vec;

    entry_t write_data;
    logic   top_nb_valid;

    logic             accept;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    word_t            hit_image;
    word_t            hit_layer;
    logic             full;
    logic             do_update;

    assign write_data = '{key: frame_number, image: image_handle, layer: layer_handle};

    genvar gi;
    generate
        for (gi = 0; gi < CACHE_ENTRIES; gi++)
        begin : g_cell
            if (gi == CACHE_ENTRIES - 1)
            begin : g_top
                frc_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl[gi]),
                    .write_data (write_data),
                    .nb_valid   (top_nb_valid),
                    .nb_data    (write_data),
                    .match_key  (frame_number),
                    .valid      (cell_valid[gi]),
                    .data       (cell_data[gi]),
                    .match      (match_vec[gi])
                );
            end
            else
            begin : g_mid
                frc_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl[gi]),
                    .write_data (write_data),
                    .nb_valid   (cell_valid[gi+1]),
                    .nb_data    (cell_data[gi+1]),
                    .match_key  (frame_number),
                    .valid      (cell_valid[gi]),
                    .data       (cell_data[gi]),
                    .match      (match_vec[gi])
                );
            end
            assign valid_vec[gi] = cell_valid[gi];
        end
    endgenerate

    // Stored keys are unique, so at most one cell matches and an OR merge
    // of the gated cell outputs picks the hit.
    always_comb
    begin
        hit_idx   = '0;
        hit_image = '0;
        hit_layer = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                hit_idx   = hit_idx | IDX_W'(i);
                hit_image = hit_image | cell_data[i].image;
                hit_layer = hit_layer | cell_data[i].layer;
            end
        end
    end

    assign hit       = |match_vec;
    assign full      = (count_reg == CNT_FULL);
    assign accept    = start && (state_reg == ST_IDLE);
    assign do_update = hit_layer[WORD_W-1] && !layer_handle[31];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        found_next   = 1'b0;
        slot_next    = '0;
        image_next   = '0;
        layer_next   = '0;
        release_next = 1'b0;
        last_next    = 1'b1;
        top_nb_valid = 1'b0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            cell_ctrl[i].op = CELL_HOLD;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_LOOKUP:
                        begin
                            done_next = 1'b1;
                            if (hit)
                            begin
                                found_next = 1'b1;
                                slot_next  = SLOT_W'(32'(hit_idx));
                                image_next = hit_image;
                                layer_next = hit_layer;
                            end
                            else
                            begin
                                image_next = NEG_ONE;
                                layer_next = NEG_ONE;
                            end
                        end
                        KIND_INSERT:
                        begin
                            done_next = 1'b1;
                            if (hit)
                            begin
                                found_next = 1'b1;
                                slot_next  = SLOT_W'(32'(hit_idx));
                                image_next = do_update ? image_handle : hit_image;
                                layer_next = do_update ? layer_handle : hit_layer;
                                for (int i = 0; i < CACHE_ENTRIES; i++)
                                begin
                                    if (match_vec[i] && do_update)
                                    begin
                                        cell_ctrl[i].op = CELL_UPDATE;
                                    end
                                end
                            end
                            else if (!full)
                            begin
                                slot_next  = SLOT_W'(32'(count_reg));
                                image_next = image_handle;
                                layer_next = layer_handle;
                                count_next = count_reg + CNT_ONE;
                                for (int i = 0; i < CACHE_ENTRIES; i++)
                                begin
                                    if (count_reg == CNT_W'(i))
                                    begin
                                        cell_ctrl[i].op = CELL_WRITE;
                                    end
                                end
                            end
                            else
                            begin
                                // Evict the oldest entry: the row shifts down one
                                // place and the new entry enters at the top.
                                slot_next    = SLOT_TOP;
                                image_next   = cell_data[0].image;
                                layer_next   = cell_data[0].layer;
                                release_next = 1'b1;
                                top_nb_valid = 1'b1;
                                for (int i = 0; i < CACHE_ENTRIES; i++)
                                begin
                                    cell_ctrl[i].op = CELL_SHIFT;
                                end
                            end
                        end
                        KIND_CLEAR:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_CLEAR;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                // Each cycle drains cell 0 and shifts an empty entry in at the top.
                done_next    = 1'b1;
                slot_next    = SLOT_W'(32'(idx_reg));
                image_next   = cell_data[0].image;
                layer_next   = cell_data[0].layer;
                release_next = 1'b1;
                last_next    = (count_reg == CNT_ONE);
                count_next   = count_reg - CNT_ONE;
                idx_next     = idx_reg + IDX_W'(1);
                for (int i = 0; i < CACHE_ENTRIES; i++)
                begin
                    cell_ctrl[i].op = CELL_SHIFT;
                end
                if (count_reg == CNT_ONE)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        image_reg   <= image_next;
        layer_reg   <= layer_next;
        release_reg <= release_next;
        last_reg    <= last_next;
    end

    assign busy        = (state_reg == ST_CLEAR);
    assign done        = done_reg;
    assign found       = found_reg;
    assign slot        = slot_reg;
    assign image_out   = image_reg;
    assign layer_out   = layer_reg;
    assign release_res = release_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("entry count differs from number of valid cells");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matches the key");

    a_clear_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (count_reg != '0))
        else $error("clear sequencer running on an empty table");

    a_clear_beats_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !last_reg) |=> done_reg)
        else $error("gap between clear result beats");

    a_clear_enters_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_CLEAR) && (count_reg != '0)) |=> busy)
        else $error("clear of a filled table did not start the drain");
`endif

endmodule
